[src/mtt_pkg.sv]
package mtt_pkg;

    localparam int MAX_SLOTS     = 16;
    localparam int SLOT_W        = 4;
    localparam int NUM_SLOTS_DEF = 16;

    // Request codes
    localparam logic [2:0] REQ_ALLOC   = 3'd0;
    localparam logic [2:0] REQ_FREE    = 3'd1;
    localparam logic [2:0] REQ_INIT    = 3'd2;
    localparam logic [2:0] REQ_SETTIME = 3'd3;
    localparam logic [2:0] REQ_TICK    = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_GRANT  = 2'd0;
    localparam logic [1:0] KIND_FAIL   = 2'd1;
    localparam logic [1:0] KIND_EXPIRE = 2'd2;

    // Slot states
    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    localparam logic [4:0] TASK_NONE = 5'd16;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  slot;
        logic [3:0]  queue_id;
        logic [7:0]  payload;
        logic [31:0] timeout;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  out_slot;
        logic [3:0]  out_queue;
        logic [7:0]  out_payload;
        logic        switch_task;
        logic [31:0] tick_count;
        logic        last;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              op_en;
        logic              walk_en;
        logic              drain_en;
        logic [SLOT_W-1:0] walk_idx;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hold_valid;
        logic out_free;
    } dp_status_t;

endpackage

[src/mtt_ctrl.sv]
module mtt_ctrl #(
    parameter int NUM_SLOTS = mtt_pkg::NUM_SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic [2:0]            req_type,
    output logic                  req_stall,
    input  mtt_pkg::dp_status_t   sts,
    output mtt_pkg::ctrl_cmd_t    cmd
);

    localparam int ACTIVE = (NUM_SLOTS < mtt_pkg::MAX_SLOTS) ? NUM_SLOTS : mtt_pkg::MAX_SLOTS;
    localparam int IDX_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd.op_en    = 1'b0;
        cmd.walk_en  = 1'b0;
        cmd.drain_en = 1'b0;
        cmd.walk_idx = mtt_pkg::SLOT_W'(idx_reg);
        req_stall    = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op_en = 1'b1;
                    if (req_type == mtt_pkg::REQ_TICK)
                    begin
                        state_next = S_WALK;
                        idx_next   = '0;
                    end
                    else if (req_type == mtt_pkg::REQ_ALLOC)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_WALK:
            begin
                // A fired slot may need to push the held result, so wait for room.
                cmd.walk_en = !(sts.hold_valid && !sts.out_free);
                if (cmd.walk_en)
                begin
                    if (idx_reg == IDX_W'(ACTIVE - 1))
                        state_next = S_DRAIN;
                    else
                        idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (!sts.hold_valid)
                    state_next = S_IDLE;
                else if (sts.out_free)
                begin
                    cmd.drain_en = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

[src/mtt_datapath.sv]
module mtt_datapath #(
    parameter int NUM_SLOTS = mtt_pkg::NUM_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mtt_pkg::req_t       req_beat,
    input  logic                cfg_we,
    input  logic [4:0]          cfg_wdata,
    input  mtt_pkg::ctrl_cmd_t  cmd,
    output mtt_pkg::dp_status_t sts,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output mtt_pkg::rsp_t       rsp_beat
);

    localparam int ACTIVE = (NUM_SLOTS < mtt_pkg::MAX_SLOTS) ? NUM_SLOTS : mtt_pkg::MAX_SLOTS;
    localparam int IDX_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] slot;
        logic [3:0] queue;
        logic [7:0] payload;
    } hold_t;

    logic [1:0]  status_reg  [ACTIVE];
    logic [1:0]  status_next [ACTIVE];
    logic [31:0] count_reg   [ACTIVE];
    logic [31:0] count_next  [ACTIVE];
    logic [3:0]  queue_reg   [ACTIVE];
    logic [3:0]  queue_next  [ACTIVE];
    logic [7:0]  payload_reg [ACTIVE];
    logic [7:0]  payload_next[ACTIVE];

    logic [31:0]    ticks_reg;
    logic [31:0]    ticks_next;
    logic [4:0]     task_slot_reg;
    logic [4:0]     task_slot_next;
    logic           hold_valid_reg;
    logic           hold_valid_next;
    hold_t          hold_reg;
    hold_t          hold_next;
    logic           sw_reg;
    logic           sw_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    mtt_pkg::rsp_t  out_reg;
    mtt_pkg::rsp_t  out_next;

    logic [IDX_W-1:0] walk_slot;
    logic [IDX_W-1:0] req_slot;
    logic             req_slot_ok;
    logic             walk_run;
    logic             fire;
    logic             found;
    logic [IDX_W-1:0] found_idx;
    logic             out_free;

    assign out_free       = !out_valid_reg || !rsp_stall;
    assign sts.hold_valid = hold_valid_reg;
    assign sts.out_free   = out_free;
    assign rsp_valid      = out_valid_reg;
    assign rsp_beat       = out_reg;

    assign walk_slot   = cmd.walk_idx[IDX_W-1:0];
    assign req_slot    = req_beat.slot[IDX_W-1:0];
    assign req_slot_ok = ({1'b0, req_beat.slot} < (mtt_pkg::SLOT_W + 1)'(ACTIVE));
    assign walk_run    = (status_reg[walk_slot] == mtt_pkg::ST_RUN);
    assign fire        = cmd.walk_en && walk_run && (count_reg[walk_slot] == 32'd1);

    // Lowest free slot.
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = ACTIVE - 1; i >= 0; i--)
        begin
            if (status_reg[i] == mtt_pkg::ST_FREE)
            begin
                found     = 1'b1;
                found_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        status_next     = status_reg;
        count_next      = count_reg;
        queue_next      = queue_reg;
        payload_next    = payload_reg;
        ticks_next      = ticks_reg;
        task_slot_next  = task_slot_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        sw_next         = sw_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        if (out_valid_reg && !rsp_stall)
            out_valid_next = 1'b0;

        if (cfg_we)
            task_slot_next = cfg_wdata;

        if (cmd.op_en)
        begin
            unique case (req_beat.req_type)
                mtt_pkg::REQ_ALLOC:
                begin
                    hold_valid_next = 1'b1;
                    sw_next         = 1'b0;
                    hold_next.queue   = '0;
                    hold_next.payload = '0;
                    if (found)
                    begin
                        hold_next.kind         = mtt_pkg::KIND_GRANT;
                        hold_next.slot         = mtt_pkg::SLOT_W'(found_idx);
                        status_next[found_idx] = mtt_pkg::ST_ALLOC;
                    end
                    else
                    begin
                        hold_next.kind = mtt_pkg::KIND_FAIL;
                        hold_next.slot = '0;
                    end
                end
                mtt_pkg::REQ_FREE:
                begin
                    if (req_slot_ok)
                        status_next[req_slot] = mtt_pkg::ST_FREE;
                end
                mtt_pkg::REQ_INIT:
                begin
                    if (req_slot_ok)
                    begin
                        queue_next[req_slot]   = req_beat.queue_id;
                        payload_next[req_slot] = req_beat.payload;
                    end
                end
                mtt_pkg::REQ_SETTIME:
                begin
                    if (req_slot_ok)
                    begin
                        count_next[req_slot]  = req_beat.timeout;
                        status_next[req_slot] = mtt_pkg::ST_RUN;
                    end
                end
                mtt_pkg::REQ_TICK:
                begin
                    ticks_next = ticks_reg + 32'd1;
                    sw_next    = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.walk_en && walk_run)
        begin
            count_next[walk_slot] = count_reg[walk_slot] - 32'd1;
            if (fire)
            begin
                status_next[walk_slot] = mtt_pkg::ST_ALLOC;
                if (hold_valid_reg)
                begin
                    out_valid_next       = 1'b1;
                    out_next.kind        = hold_reg.kind;
                    out_next.out_slot    = hold_reg.slot;
                    out_next.out_queue   = hold_reg.queue;
                    out_next.out_payload = hold_reg.payload;
                    out_next.switch_task = 1'b0;
                    out_next.tick_count  = ticks_reg;
                    out_next.last        = 1'b0;
                end
                hold_valid_next   = 1'b1;
                hold_next.kind    = mtt_pkg::KIND_EXPIRE;
                hold_next.slot    = cmd.walk_idx;
                hold_next.queue   = queue_reg[walk_slot];
                hold_next.payload = payload_reg[walk_slot];
                if (5'(cmd.walk_idx) == task_slot_reg)
                    sw_next = 1'b1;
            end
        end

        if (cmd.drain_en)
        begin
            out_valid_next       = 1'b1;
            out_next.kind        = hold_reg.kind;
            out_next.out_slot    = hold_reg.slot;
            out_next.out_queue   = hold_reg.queue;
            out_next.out_payload = hold_reg.payload;
            out_next.switch_task = sw_reg;
            out_next.tick_count  = ticks_reg;
            out_next.last        = 1'b1;
            hold_valid_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ACTIVE; i++)
            begin
                status_reg[i]  <= mtt_pkg::ST_FREE;
                queue_reg[i]   <= '0;
                payload_reg[i] <= '0;
            end
            ticks_reg      <= '0;
            task_slot_reg  <= mtt_pkg::TASK_NONE;
            hold_valid_reg <= 1'b0;
            sw_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            status_reg     <= status_next;
            queue_reg      <= queue_next;
            payload_reg    <= payload_next;
            ticks_reg      <= ticks_next;
            task_slot_reg  <= task_slot_next;
            hold_valid_reg <= hold_valid_next;
            sw_reg         <= sw_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Counts are only read for running slots, which settime always loads first.
    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        hold_reg  <= hold_next;
        out_reg   <= out_next;
    end

endmodule

[src/multi_timer_table.sv]
// Channel  | Handshake            | Beat
// ---------+----------------------+-------------------------------------------
// request  | req_valid, req_stall | req_beat, one request (mtt_pkg::req_t)
// response | rsp_valid, rsp_stall | rsp_beat, one result (mtt_pkg::rsp_t)
// config   | cfg_we               | cfg_wdata, the task slot
//
// Free, init, settime and unknown requests leave the controller idle. An alloc
// goes on to hand over its result from the drain state; a tick is accepted, the walk
// counter in the controller steps through the table, and the last result is handed over.
// Reset frees every slot, clears the tick count, bindings and output, and sets no task slot.
// While a result is held, a full output register stalled downstream pauses the
// walk and the final hand-over; a request is stalled while the controller is busy.
module multi_timer_table #(
    parameter int NUM_SLOTS = mtt_pkg::NUM_SLOTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  mtt_pkg::req_t req_beat,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output mtt_pkg::rsp_t rsp_beat,
    input  logic          cfg_we,
    input  logic [4:0]    cfg_wdata
);

    // The controller sequences each request; the datapath holds the slot
    // table, the tick count and a one-entry hold register. During a tick the
    // most recent expiry waits in the hold register until the walk either
    // finds another expiry (so the held one is not last) or finishes (so it
    // is last and carries the task-switch flag).
    mtt_pkg::ctrl_cmd_t  cmd;
    mtt_pkg::dp_status_t sts;

    mtt_ctrl #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req_beat.req_type),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    mtt_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_beat  (req_beat),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_beat  (rsp_beat)
    );

    // Requests that give no result leave the block ready in the next cycle.
    a_quick_ops: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall &&
         (req_beat.req_type == mtt_pkg::REQ_FREE ||
          req_beat.req_type == mtt_pkg::REQ_INIT ||
          req_beat.req_type == mtt_pkg::REQ_SETTIME)) |=> !req_stall)
        else $error("block busy after a request with no result");

    // An accepted alloc always leaves a result in the hold register.
    a_alloc_held: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req_beat.req_type == mtt_pkg::REQ_ALLOC)
        |=> sts.hold_valid)
        else $error("alloc result not held");

    // The final hand-over only happens with a held result and room at the output.
    a_drain_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drain_en |-> (sts.hold_valid && sts.out_free))
        else $error("drain without held result or output room");

    // The task-switch flag only rides on the final result of a request.
    a_switch_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_beat.switch_task) |-> rsp_beat.last)
        else $error("switch_task on a result that is not last");

endmodule

[verif/multi_timer_table_test.sv]
module multi_timer_table_test;

    // The table is built at its default size, which is also the widest that
    // a four-bit slot field can address.
    localparam int TABLE_SLOTS = mtt_pkg::NUM_SLOTS_DEF;

    // A tick walks every slot and then hands over its last beat, so the settle
    // pause spans the walk plus a margin for the block to go quiet.
    localparam int SETTLE_CYCLES = TABLE_SLOTS + 8;

    // Cycles without any accepted beat on either channel before the run is
    // declared hung. The slowest legal stretch is a tick walk plus a settle
    // pause plus random gaps.
    localparam int QUIET_LIMIT = 5000;

    localparam int PHASE_ITEMS  = 75;
    localparam int PHASE_COUNT  = 6;
    localparam int IDLE_PERCENT = 23;
    localparam int MAX_REPORTS  = 10;

    // Tracks the timer table as the block should see it and keeps the
    // response beats that are still owed, oldest first.
    class timer_tracker;
        logic [1:0]    status   [TABLE_SLOTS];
        logic [31:0]   count    [TABLE_SLOTS];
        logic [3:0]    queue_of [TABLE_SLOTS];
        logic [7:0]    data_of  [TABLE_SLOTS];
        logic [31:0]   tick_total;
        logic [4:0]    task_slot;
        mtt_pkg::rsp_t owed_beats [$];
        int            mismatches;

        function new();
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                status[i]   = mtt_pkg::ST_FREE;
                count[i]    = '0;
                queue_of[i] = '0;
                data_of[i]  = '0;
            end
            tick_total = '0;
            task_slot  = mtt_pkg::TASK_NONE;
            mismatches = 0;
        endfunction

        function void note_task_slot(logic [4:0] value);
            task_slot = value;
        endfunction

        // Applies one accepted request beat and queues the beats it causes.
        function void note_request(mtt_pkg::req_t r);
            mtt_pkg::rsp_t beat;
            int            fired [$];
            bit            hit_task;
            bit            in_range;
            bit            found;
            int            i;

            beat     = '0;
            hit_task = 1'b0;
            found    = 1'b0;
            in_range = (int'(r.slot) < TABLE_SLOTS);

            case (r.req_type)
                mtt_pkg::REQ_ALLOC:
                begin
                    beat.kind       = mtt_pkg::KIND_FAIL;
                    beat.tick_count = tick_total;
                    beat.last       = 1'b1;
                    for (i = 0; i < TABLE_SLOTS && !found; i++)
                    begin
                        if (status[i] == mtt_pkg::ST_FREE)
                        begin
                            status[i]     = mtt_pkg::ST_ALLOC;
                            beat.kind     = mtt_pkg::KIND_GRANT;
                            beat.out_slot = i[3:0];
                            found         = 1'b1;
                        end
                    end
                    owed_beats.push_back(beat);
                end
                mtt_pkg::REQ_FREE:
                begin
                    if (in_range)
                        status[r.slot] = mtt_pkg::ST_FREE;
                end
                mtt_pkg::REQ_INIT:
                begin
                    if (in_range)
                    begin
                        queue_of[r.slot] = r.queue_id;
                        data_of[r.slot]  = r.payload;
                    end
                end
                mtt_pkg::REQ_SETTIME:
                begin
                    if (in_range)
                    begin
                        count[r.slot]  = r.timeout;
                        status[r.slot] = mtt_pkg::ST_RUN;
                    end
                end
                mtt_pkg::REQ_TICK:
                begin
                    tick_total = tick_total + 32'd1;
                    // A zero count wraps here, so such a slot runs for 2^32 ticks.
                    for (i = 0; i < TABLE_SLOTS; i++)
                    begin
                        if (status[i] == mtt_pkg::ST_RUN)
                        begin
                            count[i] = count[i] - 32'd1;
                            if (count[i] == 32'd0)
                            begin
                                status[i] = mtt_pkg::ST_ALLOC;
                                fired.push_back(i);
                                if (i == int'(task_slot))
                                    hit_task = 1'b1;
                            end
                        end
                    end
                    // The task switch is flagged once, on the last expiry beat.
                    for (i = 0; i < fired.size(); i++)
                    begin
                        beat             = '0;
                        beat.kind        = mtt_pkg::KIND_EXPIRE;
                        beat.out_slot    = fired[i][3:0];
                        beat.out_queue   = queue_of[fired[i]];
                        beat.out_payload = data_of[fired[i]];
                        beat.tick_count  = tick_total;
                        beat.last        = (i == fired.size() - 1);
                        beat.switch_task = beat.last && hit_task;
                        owed_beats.push_back(beat);
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function string describe(mtt_pkg::rsp_t b);
            return $sformatf("kind %0d slot %0d queue %0d data %0h sw %0b tick %0d last %0b",
                             b.kind, b.out_slot, b.out_queue, b.out_payload,
                             b.switch_task, b.tick_count, b.last);
        endfunction

        // Compares one accepted response beat with the oldest owed beat.
        function void check_beat(mtt_pkg::rsp_t got);
            mtt_pkg::rsp_t want;
            bit            bad;

            if (owed_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected beat: %s", describe(got));
                return;
            end
            want = owed_beats.pop_front();
            bad  = (got.kind !== want.kind) || (got.out_slot !== want.out_slot) ||
                   (got.out_queue !== want.out_queue) ||
                   (got.out_payload !== want.out_payload) ||
                   (got.switch_task !== want.switch_task) ||
                   (got.tick_count !== want.tick_count) || (got.last !== want.last);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("beat mismatch, expected: %s", describe(want));
                    $display("                 actual: %s", describe(got));
                end
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    mtt_pkg::req_t req_beat;
    logic          rsp_valid;
    logic          rsp_stall;
    mtt_pkg::rsp_t rsp_beat;
    logic          cfg_we;
    logic [4:0]    cfg_wdata;

    // When set, neither side inserts idle or stall cycles.
    bit calm;

    timer_tracker tracker = new();

    multi_timer_table #(
        .NUM_SLOTS (TABLE_SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_beat  (req_beat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_beat  (rsp_beat),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Response side: every edge first looks at what was offered before the
    // edge, then picks the stall level for the next cycle.
    initial
    begin
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
                tracker.check_beat(rsp_beat);
            rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Watchdog: a run that stops moving on both channels is hung.
    initial
    begin
        int quiet;

        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic mtt_pkg::req_t make_req(logic [2:0] kind, logic [3:0] slot,
                                               logic [3:0] queue_id, logic [7:0] payload,
                                               logic [31:0] timeout);
        mtt_pkg::req_t r;

        r.req_type = kind;
        r.slot     = slot;
        r.queue_id = queue_id;
        r.payload  = payload;
        r.timeout  = timeout;
        return r;
    endfunction

    // Random request beat. Unused fields carry random bits as well, so every
    // bit of the beat toggles. Settime mostly loads short timeouts so that
    // slots really expire; a few load zero or a full random count.
    function automatic mtt_pkg::req_t random_req(bit alloc_heavy);
        mtt_pkg::req_t r;
        int            roll;
        int            pick;
        logic [31:0]   span;

        r.req_type = 3'($urandom);
        r.slot     = 4'($urandom);
        r.queue_id = 4'($urandom);
        r.payload  = 8'($urandom);
        r.timeout  = $urandom;
        roll       = $urandom_range(0, 99);
        if (alloc_heavy)
        begin
            if (roll < 45)      r.req_type = mtt_pkg::REQ_ALLOC;
            else if (roll < 52) r.req_type = mtt_pkg::REQ_FREE;
            else if (roll < 62) r.req_type = mtt_pkg::REQ_INIT;
            else if (roll < 75) r.req_type = mtt_pkg::REQ_SETTIME;
            else if (roll < 97) r.req_type = mtt_pkg::REQ_TICK;
            else                r.req_type = 3'($urandom_range(5, 7));
        end
        else
        begin
            if (roll < 20)      r.req_type = mtt_pkg::REQ_ALLOC;
            else if (roll < 32) r.req_type = mtt_pkg::REQ_FREE;
            else if (roll < 47) r.req_type = mtt_pkg::REQ_INIT;
            else if (roll < 67) r.req_type = mtt_pkg::REQ_SETTIME;
            else if (roll < 95) r.req_type = mtt_pkg::REQ_TICK;
            else                r.req_type = 3'($urandom_range(5, 7));
        end
        if (r.req_type == mtt_pkg::REQ_SETTIME)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)      span = $urandom_range(1, 6);
            else if (pick < 88) span = 32'd0;
            else                span = $urandom;
            r.timeout = span;
        end
        return r;
    endfunction

    // Offers one request beat, with random idle cycles ahead of it, and
    // holds it until the block takes it. Valid is only lowered when a gap
    // really follows, so it never toggles twice in one step.
    task automatic send_request(input mtt_pkg::req_t r);
        while (!calm && ($urandom_range(0, 99) < IDLE_PERCENT))
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_beat  <= r;
        do
            @(posedge clk);
        while (req_stall);
        tracker.note_request(r);
    endtask

    // Holds off new requests until every owed beat has arrived, then lets
    // the block finish a walk that produces no beats.
    task automatic settle();
        req_valid <= 1'b0;
        while (tracker.owed_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_task_slot(input logic [4:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.note_task_slot(value);
    endtask

    initial
    begin
        logic [4:0] phase_slot [PHASE_COUNT];

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_beat  <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        calm       = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Slot 2 is the task slot so that a switch rides on a
        // later expiry beat of the same tick.
        load_task_slot(5'd2);
        send_request(make_req(mtt_pkg::REQ_ALLOC, 4'd0, 4'd0, 8'd0, 32'd0));
        send_request(make_req(mtt_pkg::REQ_INIT, 4'd0, 4'd15, 8'd255, 32'd0));
        send_request(make_req(mtt_pkg::REQ_INIT, 4'd2, 4'd5, 8'hA5, 32'd0));
        send_request(make_req(mtt_pkg::REQ_INIT, 4'd3, 4'd10, 8'h5A, 32'd0));
        send_request(make_req(mtt_pkg::REQ_SETTIME, 4'd0, 4'd0, 8'd0, 32'd1));
        // Settime on free slots still starts them.
        send_request(make_req(mtt_pkg::REQ_SETTIME, 4'd2, 4'd0, 8'd0, 32'd1));
        send_request(make_req(mtt_pkg::REQ_SETTIME, 4'd3, 4'd0, 8'd0, 32'd1));
        // Three expiries in one tick; the task slot is not the last of them.
        send_request(make_req(mtt_pkg::REQ_TICK, 4'd15, 4'd15, 8'd255, 32'hFFFF_FFFF));
        // A zero timeout wraps and must not fire on the next tick.
        send_request(make_req(mtt_pkg::REQ_SETTIME, 4'd4, 4'd0, 8'd0, 32'd0));
        send_request(make_req(mtt_pkg::REQ_SETTIME, 4'd7, 4'd0, 8'd0, 32'hFFFF_FFFF));
        send_request(make_req(mtt_pkg::REQ_TICK, 4'd0, 4'd0, 8'd0, 32'd0));
        send_request(make_req(mtt_pkg::REQ_FREE, 4'd4, 4'd0, 8'd0, 32'd0));
        send_request(make_req(mtt_pkg::REQ_FREE, 4'd7, 4'd0, 8'd0, 32'd0));
        send_request(make_req(mtt_pkg::REQ_INIT, 4'd15, 4'd9, 8'd1, 32'd0));
        send_request(make_req(mtt_pkg::REQ_SETTIME, 4'd15, 4'd0, 8'd0, 32'd2));
        send_request(make_req(mtt_pkg::REQ_TICK, 4'd0, 4'd0, 8'd0, 32'd0));
        send_request(make_req(mtt_pkg::REQ_TICK, 4'd0, 4'd0, 8'd0, 32'd0));
        // Unknown request types are dropped without a beat.
        send_request(make_req(3'd5, 4'd15, 4'd15, 8'd255, 32'hFFFF_FFFF));
        send_request(make_req(3'd6, 4'd0, 4'd0, 8'd0, 32'd0));
        send_request(make_req(3'd7, 4'd15, 4'd15, 8'd255, 32'hFFFF_FFFF));
        send_request(make_req(mtt_pkg::REQ_ALLOC, 4'd0, 4'd0, 8'd0, 32'd0));
        send_request(make_req(mtt_pkg::REQ_FREE, 4'd0, 4'd0, 8'd0, 32'd0));
        send_request(make_req(mtt_pkg::REQ_ALLOC, 4'd0, 4'd0, 8'd0, 32'd0));
        // Init on an allocated slot rebinds it.
        send_request(make_req(mtt_pkg::REQ_INIT, 4'd15, 4'd0, 8'd0, 32'd0));

        // Random part, one task slot setting per phase. The first phase leans
        // on alloc so the table fills and allocs fail; the third runs with no
        // idle or stall cycles at all.
        phase_slot[0] = 5'd0;
        phase_slot[1] = 5'd15;
        phase_slot[2] = mtt_pkg::TASK_NONE;
        phase_slot[3] = 5'd31;
        phase_slot[4] = 5'($urandom_range(1, 14));
        phase_slot[5] = 5'($urandom_range(17, 30));
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            settle();
            load_task_slot(phase_slot[p]);
            calm = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(random_req(p == 0));
        end
        calm = 1'b0;

        settle();
        if (tracker.mismatches == 0 && tracker.owed_beats.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
